FILE: hw/rtl/memory_admission_spike_guard_defines.svh
// Assertion macros for the memory admission spike guard.
`ifndef MEMORY_ADMISSION_SPIKE_GUARD_DEFINES_SVH
`define MEMORY_ADMISSION_SPIKE_GUARD_DEFINES_SVH

`ifndef SYNTHESIS

`define MASG_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("masg assertion failed");

`define MASG_ASSERT_NEXT(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("masg assertion failed");

`else

`define MASG_ASSERT(label, clk, rst, prop)

`define MASG_ASSERT_NEXT(label, clk, rst, cond, prop)

`endif

`endif

FILE: hw/rtl/masg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package masg_pkg;

   localparam int unsigned BYTE_COUNT_WIDTH_DEFAULT = 48;
   localparam int unsigned KIND_WIDTH               = 3;
   localparam int unsigned TIME_WIDTH               = 32;
   localparam int unsigned WINDOW_WIDTH             = 16;
   localparam int unsigned DEPTH_WIDTH              = 4;
   localparam int unsigned CSR_INDEX_WIDTH          = 3;

   localparam logic [KIND_WIDTH-1:0] KIND_ALLOC       = 3'd0;
   localparam logic [KIND_WIDTH-1:0] KIND_RELEASE     = 3'd1;
   localparam logic [KIND_WIDTH-1:0] KIND_SCOPE_ENTER = 3'd2;
   localparam logic [KIND_WIDTH-1:0] KIND_SCOPE_EXIT  = 3'd3;
   localparam logic [KIND_WIDTH-1:0] KIND_SESSION_RST = 3'd4;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_HARD_CAP     = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SOFT_LEVEL   = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SINGLE_SPIKE = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_GROWTH_SPIKE = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_WINDOW       = 3'd4;

   localparam logic [63:0] HARD_CAP_RESET     = 64'd1073741824;
   localparam logic [63:0] SOFT_LEVEL_RESET   = 64'd268435456;
   localparam logic [63:0] SINGLE_SPIKE_RESET = 64'd67108864;
   localparam logic [63:0] GROWTH_SPIKE_RESET = 64'd134217728;
   localparam logic [WINDOW_WIDTH-1:0] WINDOW_RESET = 16'd100;

   localparam logic [DEPTH_WIDTH-1:0] DEPTH_MAX = '1;

   typedef struct packed {
      logic granted;
      logic guards_active;
      logic spike_latched;
   } res_flags_type;

endpackage

`default_nettype wire

FILE: hw/rtl/masg_req_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface masg_req_if #(
   parameter int unsigned BYTE_COUNT_WIDTH = masg_pkg::BYTE_COUNT_WIDTH_DEFAULT
);
   import masg_pkg::*;

   logic                        valid;
   logic                        ready;
   logic [KIND_WIDTH-1:0]       kind;
   logic [BYTE_COUNT_WIDTH-1:0] bytes;
   logic [TIME_WIDTH-1:0]       time_ms;

   modport source (output valid, output kind, output bytes, output time_ms, input ready);
   modport sink (input valid, input kind, input bytes, input time_ms, output ready);

endinterface

`default_nettype wire

FILE: hw/rtl/masg_rsp_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface masg_rsp_if #(
   parameter int unsigned BYTE_COUNT_WIDTH = masg_pkg::BYTE_COUNT_WIDTH_DEFAULT
);
   logic                        valid;
   logic                        ready;
   logic                        granted;
   logic                        guards_active;
   logic                        spike_latched;
   logic [BYTE_COUNT_WIDTH-1:0] estimated_bytes;

   modport source (
      output valid, output granted, output guards_active, output spike_latched,
      output estimated_bytes, input ready
   );
   modport sink (
      input valid, input granted, input guards_active, input spike_latched,
      input estimated_bytes, output ready
   );

endinterface

`default_nettype wire

FILE: hw/rtl/memory_admission_spike_guard.sv
`timescale 1ns / 1ps
`default_nettype none
`include "memory_admission_spike_guard_defines.svh"

// Channel   Direction  Handshake        Payload
// req_bus   in         valid / ready    kind, bytes, time_ms
// rsp_bus   out        valid / ready    granted, guards_active, spike_latched, estimated_bytes
// csr       in         csr_write_en     csr_index, csr_wdata
//
// One beat per cycle unless rsp_ready stalls; results pass the input and result registers.
// The session state is computed from the input register and loaded with the result register.
// Reset is synchronous and clears the state and returns the registers to their defaults.
// With rsp_ready low the result holds and the input register still takes one more beat.

module memory_admission_spike_guard #(
   parameter int unsigned BYTE_COUNT_WIDTH = masg_pkg::BYTE_COUNT_WIDTH_DEFAULT
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   masg_req_if.sink                                  req_bus,
   masg_rsp_if.source                                rsp_bus,
   input  wire logic                                 csr_write_en,
   input  wire logic [masg_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [BYTE_COUNT_WIDTH-1:0]          csr_wdata
);
   import masg_pkg::*;

   localparam int unsigned W = BYTE_COUNT_WIDTH;

   logic [W-1:0]            hard_cap_ff;
   logic [W-1:0]            soft_level_ff;
   logic [W-1:0]            single_spike_ff;
   logic [W-1:0]            growth_spike_ff;
   logic [WINDOW_WIDTH-1:0] window_ff;

   logic                    s1_valid_ff;
   logic [KIND_WIDTH-1:0]   s1_kind_ff;
   logic [W-1:0]            s1_bytes_ff;
   logic [TIME_WIDTH-1:0]   s1_time_ff;

   logic [W-1:0]            session_ff;
   logic                    spike_ff;
   logic [TIME_WIDTH-1:0]   sample_time_ff;
   logic [W-1:0]            sample_bytes_ff;
   logic [DEPTH_WIDTH-1:0]  depth_ff;

   logic [W-1:0]            session_in;
   logic                    spike_in;
   logic [TIME_WIDTH-1:0]   sample_time_in;
   logic [W-1:0]            sample_bytes_in;
   logic [DEPTH_WIDTH-1:0]  depth_in;
   res_flags_type           flags_in;

   logic                    rsp_valid_ff;
   res_flags_type           rsp_flags_ff;
   logic [W-1:0]            rsp_bytes_ff;

   logic                    out_load;
   logic                    req_take;

   assign out_load      = s1_valid_ff && (!rsp_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !s1_valid_ff || out_load;
   assign req_take      = req_bus.valid && req_bus.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         hard_cap_ff     <= HARD_CAP_RESET[W-1:0];
         soft_level_ff   <= SOFT_LEVEL_RESET[W-1:0];
         single_spike_ff <= SINGLE_SPIKE_RESET[W-1:0];
         growth_spike_ff <= GROWTH_SPIKE_RESET[W-1:0];
         window_ff       <= WINDOW_RESET;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_HARD_CAP:     hard_cap_ff     <= csr_wdata;
            CSR_SOFT_LEVEL:   soft_level_ff   <= csr_wdata;
            CSR_SINGLE_SPIKE: single_spike_ff <= csr_wdata;
            CSR_GROWTH_SPIKE: growth_spike_ff <= csr_wdata;
            CSR_WINDOW:       window_ff       <= csr_wdata[WINDOW_WIDTH-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_bus.ready) begin
         s1_valid_ff <= req_bus.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_kind_ff  <= req_bus.kind;
         s1_bytes_ff <= req_bus.bytes;
         s1_time_ff  <= req_bus.time_ms;
      end
   end

   masg_eval #(
      .BYTE_COUNT_WIDTH (W)
   ) u_eval (
      .kind              (s1_kind_ff),
      .bytes             (s1_bytes_ff),
      .time_ms           (s1_time_ff),
      .session           (session_ff),
      .spike             (spike_ff),
      .sample_time       (sample_time_ff),
      .sample_bytes      (sample_bytes_ff),
      .depth             (depth_ff),
      .hard_cap          (hard_cap_ff),
      .soft_level        (soft_level_ff),
      .single_spike      (single_spike_ff),
      .growth_spike      (growth_spike_ff),
      .window            (window_ff),
      .session_next      (session_in),
      .spike_next        (spike_in),
      .sample_time_next  (sample_time_in),
      .sample_bytes_next (sample_bytes_in),
      .depth_next        (depth_in),
      .flags             (flags_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         session_ff      <= '0;
         spike_ff        <= 1'b0;
         sample_time_ff  <= '0;
         sample_bytes_ff <= '0;
         depth_ff        <= '0;
      end else if (out_load) begin
         session_ff      <= session_in;
         spike_ff        <= spike_in;
         sample_time_ff  <= sample_time_in;
         sample_bytes_ff <= sample_bytes_in;
         depth_ff        <= depth_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_flags_ff <= flags_in;
         rsp_bytes_ff <= session_in;
      end
   end

   assign rsp_bus.valid           = rsp_valid_ff;
   assign rsp_bus.granted         = rsp_flags_ff.granted;
   assign rsp_bus.guards_active   = rsp_flags_ff.guards_active;
   assign rsp_bus.spike_latched   = rsp_flags_ff.spike_latched;
   assign rsp_bus.estimated_bytes = rsp_bytes_ff;

   // A refused allocation must leave the estimate untouched.
   `MASG_ASSERT_NEXT(a_refuse_keeps_estimate, clock, reset,
      out_load && !flags_in.granted, session_ff == $past(session_ff))

   // The pending result always mirrors the state it produced.
   `MASG_ASSERT(a_result_matches_state, clock, reset,
      !rsp_valid_ff || ((rsp_bytes_ff == session_ff)
                        && (rsp_flags_ff.spike_latched == spike_ff)))

   // An open scope always shows as active guards.
   `MASG_ASSERT(a_scope_forces_guards, clock, reset,
      !(rsp_valid_ff && (depth_ff != '0)) || rsp_flags_ff.guards_active)

endmodule

`default_nettype wire

FILE: hw/rtl/masg_eval.sv
`timescale 1ns / 1ps
`default_nettype none

module masg_eval #(
   parameter int unsigned BYTE_COUNT_WIDTH = masg_pkg::BYTE_COUNT_WIDTH_DEFAULT
) (
   input  wire logic [masg_pkg::KIND_WIDTH-1:0]   kind,
   input  wire logic [BYTE_COUNT_WIDTH-1:0]       bytes,
   input  wire logic [masg_pkg::TIME_WIDTH-1:0]   time_ms,
   input  wire logic [BYTE_COUNT_WIDTH-1:0]       session,
   input  wire logic                              spike,
   input  wire logic [masg_pkg::TIME_WIDTH-1:0]   sample_time,
   input  wire logic [BYTE_COUNT_WIDTH-1:0]       sample_bytes,
   input  wire logic [masg_pkg::DEPTH_WIDTH-1:0]  depth,
   input  wire logic [BYTE_COUNT_WIDTH-1:0]       hard_cap,
   input  wire logic [BYTE_COUNT_WIDTH-1:0]       soft_level,
   input  wire logic [BYTE_COUNT_WIDTH-1:0]       single_spike,
   input  wire logic [BYTE_COUNT_WIDTH-1:0]       growth_spike,
   input  wire logic [masg_pkg::WINDOW_WIDTH-1:0] window,
   output logic [BYTE_COUNT_WIDTH-1:0]            session_next,
   output logic                                   spike_next,
   output logic [masg_pkg::TIME_WIDTH-1:0]        sample_time_next,
   output logic [BYTE_COUNT_WIDTH-1:0]            sample_bytes_next,
   output logic [masg_pkg::DEPTH_WIDTH-1:0]       depth_next,
   output masg_pkg::res_flags_type                flags
);
   import masg_pkg::*;

   localparam int unsigned W = BYTE_COUNT_WIDTH;

   logic [W:0]          sum;
   logic [W-1:0]        now_bytes;
   logic                bytes_nz;
   logic                guards_cur;
   logic                over_cap;
   logic                refuse;
   logic [TIME_WIDTH-1:0] time_delta;
   logic [W-1:0]        growth;
   logic                growth_hit;

   assign sum        = {1'b0, session} + {1'b0, bytes};
   assign now_bytes  = sum[W] ? {W{1'b1}} : sum[W-1:0];
   assign bytes_nz   = |bytes;
   assign guards_cur = (depth != '0) || (spike && (session >= soft_level));
   assign over_cap   = (session > hard_cap) || (bytes > (hard_cap - session));
   assign refuse     = (bytes_nz && !(bytes < hard_cap)) || (guards_cur && over_cap);
   assign time_delta = time_ms - sample_time;
   assign growth     = now_bytes - sample_bytes;
   assign growth_hit = (time_ms > sample_time)
                       && (time_delta <= {{(TIME_WIDTH-WINDOW_WIDTH){1'b0}}, window})
                       && (now_bytes > sample_bytes) && (growth >= growth_spike);

   always_comb begin
      session_next      = session;
      spike_next        = spike;
      sample_time_next  = sample_time;
      sample_bytes_next = sample_bytes;
      depth_next        = depth;
      flags.granted     = 1'b1;
      unique case (kind)
         KIND_ALLOC: begin
            flags.granted = !refuse;
            if (!refuse && bytes_nz) begin
               session_next = now_bytes;
               if ((depth != '0) || (bytes >= single_spike)) begin
                  spike_next = 1'b1;
               end else begin
                  sample_time_next  = time_ms;
                  sample_bytes_next = now_bytes;
                  if (growth_hit) begin
                     spike_next = 1'b1;
                  end
                  if (now_bytes < (soft_level >> 1)) begin
                     spike_next = 1'b0;
                  end
               end
            end
         end
         KIND_RELEASE: begin
            if (bytes_nz) begin
               session_next = (session > bytes) ? (session - bytes) : '0;
            end
         end
         KIND_SCOPE_ENTER: begin
            if (depth != DEPTH_MAX) begin
               depth_next = depth + 1'b1;
            end
         end
         KIND_SCOPE_EXIT: begin
            if (depth != '0) begin
               depth_next = depth - 1'b1;
            end
         end
         KIND_SESSION_RST: begin
            session_next      = '0;
            spike_next        = 1'b0;
            sample_time_next  = '0;
            sample_bytes_next = '0;
         end
         default: begin
         end
      endcase
      flags.spike_latched = spike_next;
      flags.guards_active = (depth_next != '0) || (spike_next && (session_next >= soft_level));
   end

endmodule

`default_nettype wire

FILE: dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
   import masg_pkg::*;

   localparam int unsigned BW = BYTE_COUNT_WIDTH_DEFAULT;
   localparam logic [BW-1:0] BYTES_ALL_ONES = '1;
   localparam logic [KIND_WIDTH-1:0] KIND_SPARE_LO = 3'd5;
   localparam logic [KIND_WIDTH-1:0] KIND_SPARE_HI = 3'd7;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_UNUSED = 3'd7;
   localparam int CYCLE_LIMIT = 400000;

   typedef struct packed {
      logic [KIND_WIDTH-1:0] kind;
      logic [BW-1:0]         bytes;
      logic [TIME_WIDTH-1:0] t;
   } guard_event_type;

   typedef struct packed {
      logic          granted;
      logic          guards;
      logic          latched;
      logic [BW-1:0] est;
   } guard_status_type;

   logic clock = 1'b0;
   logic reset;
   logic csr_write_en;
   logic [CSR_INDEX_WIDTH-1:0] csr_index;
   logic [BW-1:0] csr_wdata;

   masg_req_if #(.BYTE_COUNT_WIDTH(BW)) req_bus ();
   masg_rsp_if #(.BYTE_COUNT_WIDTH(BW)) rsp_bus ();

   memory_admission_spike_guard #(.BYTE_COUNT_WIDTH(BW)) uut (
      .clock        (clock),
      .reset        (reset),
      .req_bus      (req_bus),
      .rsp_bus      (rsp_bus),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   always #2 clock = ~clock;

   // Register copies and session state of the admission guard.
   logic [BW-1:0]          cap_q, soft_q, single_q, growth_q;
   logic [WINDOW_WIDTH-1:0] window_q;
   logic [BW-1:0]          est_q, smp_b_q;
   logic [TIME_WIDTH-1:0]  smp_t_q;
   logic                   latch_q;
   logic [DEPTH_WIDTH-1:0] depth_q;

   guard_event_type  pending_events[$];
   guard_status_type expected_status_q[$];
   guard_event_type  next_ev;
   logic [TIME_WIDTH-1:0] tnow;
   int issued, checked, queued, fails, refused, latched_seen, settings, cycles;
   int send_gap, hold_cycles;
   bit calm;

   function automatic logic guards_on();
      return depth_q != 0 || (latch_q && est_q >= soft_q);
   endfunction

   function automatic guard_status_type apply_event(input guard_event_type ev);
      guard_status_type st;
      logic [BW-1:0] b, total;
      logic over, ok, grew;
      b = ev.bytes;
      ok = 1'b1;
      case (ev.kind)
         KIND_ALLOC: begin
            if (b != 0 && !(b < cap_q)) begin
               ok = 1'b0;
            end else begin
               if (est_q > cap_q) over = 1'b1;
               else over = b > cap_q - est_q;
               if (guards_on() && over) begin
                  ok = 1'b0;
               end else if (b != 0) begin
                  total = (b > BYTES_ALL_ONES - est_q) ? BYTES_ALL_ONES : est_q + b;
                  est_q = total;
                  if (depth_q != 0 || b >= single_q) begin
                     latch_q = 1'b1;
                  end else begin
                     grew = ev.t > smp_t_q && (ev.t - smp_t_q) <= {16'd0, window_q} &&
                            total > smp_b_q && (total - smp_b_q) >= growth_q;
                     smp_t_q = ev.t;
                     smp_b_q = total;
                     if (grew) latch_q = 1'b1;
                     if (total < (soft_q >> 1)) latch_q = 1'b0;
                  end
               end
            end
         end
         KIND_RELEASE: begin
            if (b != 0) est_q = (est_q > b) ? est_q - b : '0;
         end
         KIND_SCOPE_ENTER: begin
            if (depth_q != DEPTH_MAX) depth_q = depth_q + 1'b1;
         end
         KIND_SCOPE_EXIT: begin
            if (depth_q != 0) depth_q = depth_q - 1'b1;
         end
         KIND_SESSION_RST: begin
            est_q = '0;
            latch_q = 1'b0;
            smp_t_q = '0;
            smp_b_q = '0;
         end
         default: begin
         end
      endcase
      st.granted = ok;
      st.guards = guards_on();
      st.latched = latch_q;
      st.est = est_q;
      return st;
   endfunction

   function automatic logic [BW-1:0] rand48();
      logic [63:0] r;
      r = {$urandom, $urandom};
      return r[BW-1:0];
   endfunction

   function automatic logic [BW-1:0] pick_bytes();
      logic [BW-1:0] scale;
      scale = (soft_q >> 2) + 48'd3;
      case ($urandom_range(0, 11))
         0: return '0;
         1: return BYTES_ALL_ONES;
         2: return rand48();
         3: return single_q + $urandom_range(0, 4) - 2;
         4: return growth_q + $urandom_range(0, 4) - 2;
         5: return cap_q + $urandom_range(0, 4) - 2;
         6: return (soft_q >> 1) + $urandom_range(0, 4) - 2;
         default: return rand48() % scale;
      endcase
   endfunction

   function automatic logic [TIME_WIDTH-1:0] next_time();
      int span;
      span = int'(window_q) + int'(window_q) / 2 + 2;
      case ($urandom_range(0, 9))
         0: tnow = $urandom;
         1: tnow = tnow - $urandom_range(0, 50);
         2: tnow = tnow;
         default: tnow = tnow + $urandom_range(0, span);
      endcase
      return tnow;
   endfunction

   task automatic queue_event(input logic [KIND_WIDTH-1:0] kind, input logic [BW-1:0] bytes,
                              input logic [TIME_WIDTH-1:0] t);
      pending_events.push_back('{kind: kind, bytes: bytes, t: t});
      queued++;
   endtask

   task automatic queue_random();
      int sel, depth, n, k;
      sel = $urandom_range(0, 99);
      if (sel < 50) begin
         queue_event(KIND_ALLOC, pick_bytes(), next_time());
      end else if (sel < 68) begin
         queue_event(KIND_RELEASE, pick_bytes(), $urandom);
      end else if (sel < 76) begin
         queue_event(KIND_SCOPE_ENTER, rand48(), $urandom);
      end else if (sel < 84) begin
         queue_event(KIND_SCOPE_EXIT, rand48(), $urandom);
      end else if (sel < 87) begin
         queue_event(KIND_SESSION_RST, rand48(), $urandom);
      end else if (sel < 89) begin
         queue_event(KIND_WIDTH'($urandom_range(KIND_SPARE_LO, KIND_SPARE_HI)), rand48(),
                     $urandom);
      end else if (sel < 91) begin
         // A nested scope run that may reach the depth ceiling, then unwound with one exit more than it entered.
         depth = $urandom_range(10, 17);
         n = $urandom_range(1, 3);
         for (k = 0; k < depth; k++) queue_event(KIND_SCOPE_ENTER, rand48(), $urandom);
         for (k = 0; k < n; k++) queue_event(KIND_ALLOC, pick_bytes(), next_time());
         for (k = 0; k <= depth; k++) queue_event(KIND_SCOPE_EXIT, rand48(), $urandom);
      end else begin
         queue_event(KIND_ALLOC, pick_bytes(), next_time());
      end
   endtask

   task automatic queue_randoms(input int n);
      int start;
      start = queued;
      while (queued - start < n) queue_random();
   endtask

   task automatic drain();
      do @(negedge clock); while (pending_events.size() != 0 || issued != checked);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_WIDTH-1:0] idx, input logic [BW-1:0] val);
      @(posedge clock);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_write_en <= 1'b0;
      case (idx)
         CSR_HARD_CAP:     cap_q = val;
         CSR_SOFT_LEVEL:   soft_q = val;
         CSR_SINGLE_SPIKE: single_q = val;
         CSR_GROWTH_SPIKE: growth_q = val;
         CSR_WINDOW:       window_q = val[WINDOW_WIDTH-1:0];
         default: begin
         end
      endcase
   endtask

   task automatic set_regs(input logic [BW-1:0] cap, input logic [BW-1:0] soft_lvl,
                           input logic [BW-1:0] single, input logic [BW-1:0] growth,
                           input logic [WINDOW_WIDTH-1:0] win);
      write_reg(CSR_HARD_CAP, cap);
      write_reg(CSR_SOFT_LEVEL, soft_lvl);
      write_reg(CSR_SINGLE_SPIKE, single);
      write_reg(CSR_GROWTH_SPIKE, growth);
      write_reg(CSR_WINDOW, {{(BW - WINDOW_WIDTH){1'b0}}, win});
      write_reg(CSR_UNUSED, rand48());
      settings++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (!req_bus.valid || req_bus.ready) begin
         if (send_gap != 0) begin
            send_gap--;
            req_bus.valid <= 1'b0;
         end else if (pending_events.size() != 0) begin
            next_ev = pending_events.pop_front();
            req_bus.valid <= 1'b1;
            req_bus.kind <= next_ev.kind;
            req_bus.bytes <= next_ev.bytes;
            req_bus.time_ms <= next_ev.t;
            issued++;
            if (!calm && $urandom_range(0, 15) == 0) send_gap = $urandom_range(1, 18);
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin : result_monitor
      guard_status_type want;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            expected_status_q.push_back(apply_event('{kind: req_bus.kind,
                                                      bytes: req_bus.bytes,
                                                      t: req_bus.time_ms}));
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_status_q.size() == 0) begin
               $error("result beat arrived with no request outstanding");
               fails++;
            end else begin
               want = expected_status_q.pop_front();
               checked++;
               if (!want.granted) refused++;
               if (want.latched) latched_seen++;
               if (rsp_bus.granted !== want.granted) begin
                  $error("granted: expected %0d, got %0d", want.granted, rsp_bus.granted);
                  fails++;
               end
               if (rsp_bus.guards_active !== want.guards) begin
                  $error("guards_active: expected %0d, got %0d", want.guards,
                         rsp_bus.guards_active);
                  fails++;
               end
               if (rsp_bus.spike_latched !== want.latched) begin
                  $error("spike_latched: expected %0d, got %0d", want.latched,
                         rsp_bus.spike_latched);
                  fails++;
               end
               if (rsp_bus.estimated_bytes !== want.est) begin
                  $error("estimated_bytes: expected %0d, got %0d", want.est,
                         rsp_bus.estimated_bytes);
                  fails++;
               end
            end
         end
         if (hold_cycles != 0) begin
            hold_cycles--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
            if (!calm && $urandom_range(0, 15) == 0) hold_cycles = $urandom_range(1, 18);
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   initial begin
      int k;
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.kind = '0;
      req_bus.bytes = '0;
      req_bus.time_ms = '0;
      rsp_bus.ready = 1'b0;
      csr_write_en = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      cap_q = HARD_CAP_RESET[BW-1:0];
      soft_q = SOFT_LEVEL_RESET[BW-1:0];
      single_q = SINGLE_SPIKE_RESET[BW-1:0];
      growth_q = GROWTH_SPIKE_RESET[BW-1:0];
      window_q = WINDOW_RESET;
      est_q = '0;
      smp_b_q = '0;
      smp_t_q = '0;
      latch_q = 1'b0;
      depth_q = '0;
      tnow = 32'd1000;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Power-on register values.
      settings = 1;
      queue_event(KIND_ALLOC, '0, 32'd5);
      queue_event(KIND_ALLOC, 48'd1, 32'd10);
      queue_event(KIND_ALLOC, SINGLE_SPIKE_RESET[BW-1:0], 32'd20);
      queue_event(KIND_ALLOC, HARD_CAP_RESET[BW-1:0], 32'd30);
      queue_event(KIND_ALLOC, BYTES_ALL_ONES, 32'd40);
      queue_event(KIND_RELEASE, BYTES_ALL_ONES, 32'd0);
      queue_event(KIND_RELEASE, '0, 32'd0);
      queue_event(KIND_ALLOC, 48'd1000, 32'd50);
      queue_event(KIND_SCOPE_ENTER, '0, 32'd0);
      queue_event(KIND_ALLOC, 48'd4096, 32'd60);
      queue_event(KIND_SCOPE_EXIT, '0, 32'd0);
      queue_event(KIND_SCOPE_EXIT, '0, 32'd0);
      queue_event(KIND_SESSION_RST, BYTES_ALL_ONES, '1);
      queue_event(KIND_ALLOC, 48'd209715200, 32'd65);
      queue_event(KIND_ALLOC, 48'd66060288, 32'd70);
      queue_event(KIND_ALLOC, 48'd943718400, 32'd80);
      for (k = int'(KIND_SPARE_LO); k <= int'(KIND_SPARE_HI); k++) begin
         queue_event(KIND_WIDTH'(k), BYTES_ALL_ONES, '1);
      end
      queue_event(KIND_ALLOC, 48'd1, '1);
      queue_event(KIND_ALLOC, 48'd1, '0);
      queue_randoms(250);
      drain();

      // Everything at its ceiling, with a saturating estimate.
      set_regs('1, '1, '1, '1, '1);
      queue_event(KIND_SESSION_RST, '0, '0);
      queue_event(KIND_ALLOC, BYTES_ALL_ONES - 1'b1, 32'd1);
      queue_event(KIND_ALLOC, BYTES_ALL_ONES - 1'b1, 32'd2);
      queue_event(KIND_ALLOC, 48'd5, 32'd3);
      queue_randoms(150);
      drain();

      // Zero cap refuses every nonzero allocation.
      set_regs('0, '0, '0, '0, '0);
      queue_randoms(100);
      drain();

      set_regs(48'd10000, 48'd4000, 48'd1500, 48'd2500, 16'd50);
      queue_randoms(300);
      drain();

      // Growth threshold below the single-spike size so growth detection shows on its own.
      set_regs(48'd1 << 20, 48'd1 << 18, 48'd1 << 17, 48'd1 << 16, 16'd7);
      queue_randoms(300);
      drain();

      repeat (3) begin
         set_regs(rand48() >> $urandom_range(0, 47), rand48() >> $urandom_range(0, 47),
                  rand48() >> $urandom_range(0, 47), rand48() >> $urandom_range(0, 47),
                  16'($urandom_range(0, 65535) >> $urandom_range(0, 15)));
         queue_randoms(150);
         drain();
      end

      calm = 1'b1;
      set_regs(48'd20000, 48'd6000, 48'd3000, 48'd4000, 16'd30);
      queue_randoms(200);
      drain();

      repeat (8) @(posedge clock);
      $display("Checked %0d result beats over %0d register settings.", checked, settings);
      $display("%0d allocs were refused and %0d results carried a set spike latch.",
               refused, latched_seen);
      if (fails == 0 && expected_status_q.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
